// File: rtl/core/rwc_pkg.sv
`default_nettype none

package rwc_pkg;

  // Beat geometry
  localparam int BYTES_PER_BEAT = 8;
  localparam int DATA_BYTES     = 8;
  localparam int DATA_W         = 8 * DATA_BYTES;
  localparam int ACC_W          = 32;
  localparam int OFFSET_W       = 8;

  // Lanes that carry real bytes; wider beats see zero bytes above these
  localparam int LANES_USED = (BYTES_PER_BEAT < DATA_BYTES) ? BYTES_PER_BEAT : DATA_BYTES;

  // Lane reduction width: weights 8 down to 1 sum to 36, and 36 * 128 fits in 14 signed bits
  localparam int LANE_W = 20;
  localparam int EXT_W  = ACC_W - LANE_W;

  // Per-beat constants, modulo 2^32
  localparam logic [ACC_W-1:0] BEAT_C = ACC_W'(BYTES_PER_BEAT);
  localparam logic [ACC_W-1:0] TRI_C  = ACC_W'((BYTES_PER_BEAT * (BYTES_PER_BEAT + 1)) / 2);

  typedef struct packed {
    logic [LANE_W-1:0] sum;       // two's complement sum of lanes
    logic [LANE_W-1:0] weighted;  // two's complement weighted sum of lanes
  } lane_sums_t;

  typedef struct packed {
    logic              step;
    logic              start;
    logic [ACC_W-1:0]  seed_sum;
    logic [ACC_W-1:0]  seed_weighted;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rolling_weak_checksum_block.sv
// Rolling weak checksum over a stream of signed bytes, eight to a beat with
// the first stream byte in the low bits. Each accepted request yields one
// result: the plain sum s1, the weighted sum s2 and the byte count of the
// run, all modulo 2^32, plus an echo of last. A request with start_req set
// reloads the sums from the seeds and restarts the count before its own
// bytes are added; last only tags the result and does not end accumulation.
// Throughput is one request per clock while out_ready is high; a held
// result stalls the input. An accepted request sits in the input register
// until the result slot is free, then passes through the lane reduction and
// accumulator adders into the accumulator registers, which also serve as the
// result register. byte_offset is written through cfg_we/cfg_wdata and must
// only change while no request is in flight.
`default_nettype none

module rolling_weak_checksum_block (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rwc_pkg::DATA_W-1:0]   in_data_bytes,
  input  wire logic                         in_start_req,
  input  wire logic [rwc_pkg::ACC_W-1:0]    in_seed_sum,
  input  wire logic [rwc_pkg::ACC_W-1:0]    in_seed_weighted,
  input  wire logic                         in_last,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rwc_pkg::ACC_W-1:0]         out_sum_plain,
  output logic [rwc_pkg::ACC_W-1:0]         out_sum_weighted,
  output logic [rwc_pkg::ACC_W-1:0]         out_bytes_done,
  output logic                              out_last_out,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [rwc_pkg::OFFSET_W-1:0] cfg_wdata
);

  logic                           req_valid_r;
  logic [rwc_pkg::DATA_W-1:0]     req_data_r;
  logic                           req_start_r;
  logic [rwc_pkg::ACC_W-1:0]      req_seed_sum_r;
  logic [rwc_pkg::ACC_W-1:0]      req_seed_weighted_r;
  logic                           req_last_r;
  logic                           out_valid_r;
  logic                           out_last_r;
  logic [rwc_pkg::OFFSET_W-1:0]   byte_offset_r;
  logic                           advance;
  logic                           in_fire;
  rwc_pkg::lane_sums_t            lanes;
  rwc_pkg::acc_ctrl_t             acc_ctrl;

  // Move the held request into the accumulators whenever the result slot
  // is empty or being drained this cycle.
  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  // Take a new request when the input register is free or emptying.
  assign in_ready = !req_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // Input register: hold the request until the accumulators take it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_data_r          <= in_data_bytes;
      req_start_r         <= in_start_req;
      req_seed_sum_r      <= in_seed_sum;
      req_seed_weighted_r <= in_seed_weighted;
      req_last_r          <= in_last;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
    end else if (cfg_we) begin
      byte_offset_r <= cfg_wdata;
    end
  end

  rwc_lanes u_lanes (
    .data_bytes (req_data_r),
    .lanes      (lanes)
  );

  always_comb begin
    acc_ctrl.step          = advance;
    acc_ctrl.start         = req_start_r;
    acc_ctrl.seed_sum      = req_seed_sum_r;
    acc_ctrl.seed_weighted = req_seed_weighted_r;
  end

  // The accumulators only move on advance, which needs the result slot free,
  // so their outputs stay stable while a result waits.
  rwc_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (acc_ctrl),
    .lanes        (lanes),
    .byte_offset  (byte_offset_r),
    .sum_plain    (out_sum_plain),
    .sum_weighted (out_sum_weighted),
    .bytes_done   (out_bytes_done)
  );

  // Result valid: set on advance, drop once taken with nothing behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last_r <= req_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_last_out = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/rwc_lanes.sv
`default_nettype none

// Reduce the bytes of one beat to a plain and a position-weighted sum.
module rwc_lanes (
  input  wire logic [rwc_pkg::DATA_W-1:0] data_bytes,
  output rwc_pkg::lane_sums_t             lanes
);

  always_comb begin : reduce
    logic signed [rwc_pkg::LANE_W-1:0] sum_v;
    logic signed [rwc_pkg::LANE_W-1:0] wsum_v;
    logic signed [rwc_pkg::LANE_W-1:0] byte_v;
    logic signed [rwc_pkg::LANE_W-1:0] weight_v;
    sum_v  = '0;
    wsum_v = '0;
    for (int k = 0; k < rwc_pkg::LANES_USED; k++) begin
      byte_v   = rwc_pkg::LANE_W'($signed(data_bytes[8*k +: 8]));
      weight_v = rwc_pkg::LANE_W'(rwc_pkg::BYTES_PER_BEAT - k);
      sum_v    = sum_v + byte_v;
      wsum_v   = wsum_v + weight_v * byte_v;
    end
    lanes.sum      = sum_v;
    lanes.weighted = wsum_v;
  end

endmodule

`default_nettype wire

// File: rtl/core/rwc_acc.sv
`default_nettype none

// Running sums and byte count; the registers double as the result payload.
module rwc_acc (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rwc_pkg::acc_ctrl_t           ctrl,
  input  wire rwc_pkg::lane_sums_t          lanes,
  input  wire logic [rwc_pkg::OFFSET_W-1:0] byte_offset,
  output logic [rwc_pkg::ACC_W-1:0]         sum_plain,
  output logic [rwc_pkg::ACC_W-1:0]         sum_weighted,
  output logic [rwc_pkg::ACC_W-1:0]         bytes_done
);

  logic [rwc_pkg::ACC_W-1:0] plain_acc_r,    plain_acc_nxt;
  logic [rwc_pkg::ACC_W-1:0] weighted_acc_r, weighted_acc_nxt;
  logic [rwc_pkg::ACC_W-1:0] byte_pos_r,     byte_pos_nxt;
  logic [rwc_pkg::ACC_W-1:0] s1_base, s2_base, pos_base;
  logic [rwc_pkg::ACC_W-1:0] lane_sum_x, lane_wsum_x, offset_x;

  always_comb begin
    lane_sum_x  = {{rwc_pkg::EXT_W{lanes.sum[rwc_pkg::LANE_W-1]}}, lanes.sum};
    lane_wsum_x = {{rwc_pkg::EXT_W{lanes.weighted[rwc_pkg::LANE_W-1]}}, lanes.weighted};
    offset_x    = {{(rwc_pkg::ACC_W - rwc_pkg::OFFSET_W){1'b0}}, byte_offset};

    // start loads seeds before this beat is folded in
    s1_base  = ctrl.start ? ctrl.seed_sum      : plain_acc_r;
    s2_base  = ctrl.start ? ctrl.seed_weighted : weighted_acc_r;
    pos_base = ctrl.start ? '0                 : byte_pos_r;

    plain_acc_nxt    = plain_acc_r;
    weighted_acc_nxt = weighted_acc_r;
    byte_pos_nxt     = byte_pos_r;
    if (ctrl.step) begin
      weighted_acc_nxt = s2_base + rwc_pkg::BEAT_C * s1_base + lane_wsum_x
                         + rwc_pkg::TRI_C * offset_x;
      plain_acc_nxt    = s1_base + lane_sum_x + rwc_pkg::BEAT_C * offset_x;
      byte_pos_nxt     = pos_base + rwc_pkg::BEAT_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_acc_r    <= '0;
      weighted_acc_r <= '0;
      byte_pos_r     <= '0;
    end else begin
      plain_acc_r    <= plain_acc_nxt;
      weighted_acc_r <= weighted_acc_nxt;
      byte_pos_r     <= byte_pos_nxt;
    end
  end

  assign sum_plain    = plain_acc_r;
  assign sum_weighted = weighted_acc_r;
  assign bytes_done   = byte_pos_r;

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles the receiver sits on its hands while the sender keeps pushing.
  localparam int SQUEEZE_CYCLES = 64;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_ROWS = 16;

  // One request as the sender offers it.
  typedef struct packed {
    logic [rwc_pkg::DATA_W-1:0] data;
    logic                       start;
    logic [rwc_pkg::ACC_W-1:0]  seed_sum;
    logic [rwc_pkg::ACC_W-1:0]  seed_weighted;
    logic                       last;
  } beat_req_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [rwc_pkg::ACC_W-1:0] plain;
    logic [rwc_pkg::ACC_W-1:0] weighted;
    logic [rwc_pkg::ACC_W-1:0] count;
    logic                      last;
  } beat_res_t;

  // Directed row: optional byte_offset write ahead of the request, and the
  // expected sums where they are obvious by hand (typed = 1).
  typedef struct packed {
    logic                         set_offset;
    logic [rwc_pkg::OFFSET_W-1:0] offset;
    logic                         start;
    logic [rwc_pkg::DATA_W-1:0]   data;
    logic [rwc_pkg::ACC_W-1:0]    seed_sum;
    logic [rwc_pkg::ACC_W-1:0]    seed_weighted;
    logic                         last;
    logic                         typed;
    logic [rwc_pkg::ACC_W-1:0]    exp_plain;
    logic [rwc_pkg::ACC_W-1:0]    exp_weighted;
    logic [rwc_pkg::ACC_W-1:0]    exp_count;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // no start straight out of reset: seeds must be ignored, sums begin at zero
    '{1'b0, 8'd0, 1'b0, 64'h0, 32'hDEADBEEF, 32'hCAFEF00D, 1'b0, 1'b1, 32'h0, 32'h0, 32'd8},
    '{1'b0, 8'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
    '{1'b0, 8'd0, 1'b1, 64'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0, 32'd8},
    // all bytes -1
    '{1'b0, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1,
      32'hFFFF_FFF8, 32'hFFFF_FFDC, 32'd8},
    // all bytes at the positive and negative extremes
    '{1'b0, 8'd0, 1'b1, 64'h7F7F_7F7F_7F7F_7F7F, 32'h0, 32'h0, 1'b0, 1'b1,
      32'h0000_03F8, 32'h0000_11DC, 32'd8},
    '{1'b0, 8'd0, 1'b1, 64'h8080_8080_8080_8080, 32'h0, 32'h0, 1'b0, 1'b1,
      32'hFFFF_FC00, 32'hFFFF_EE00, 32'd8},
    // seeds at their maximum wrap at once
    '{1'b0, 8'd0, 1'b1, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
      32'hFFFF_FFFF, 32'hFFFF_FFF7, 32'd8},
    // keep accumulating after a beat marked last
    '{1'b0, 8'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{1'b0, 8'd0, 1'b0, 64'h8000_0000_0000_0001, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{1'b0, 8'd0, 1'b1, 64'h0000_0000_0000_00FF, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0,
      32'h0, 32'h0, 32'h0},
    // largest byte_offset
    '{1'b1, 8'd255, 1'b1, 64'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0000_07F8, 32'h0000_23DC, 32'd8},
    '{1'b0, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1,
      32'h0000_07F0, 32'h0000_23B8, 32'd8},
    '{1'b0, 8'd0, 1'b0, 64'h8080_8080_8080_8080, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{1'b0, 8'd0, 1'b0, 64'h7F7F_7F7F_7F7F_7F7F, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
    '{1'b1, 8'd1, 1'b1, 64'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'd8, 32'h0000_0024, 32'd8},
    '{1'b0, 8'd0, 1'b0, 64'hFF00_7F80_0180_FE7F, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [rwc_pkg::DATA_W-1:0] in_data_bytes;
  logic in_start_req;
  logic [rwc_pkg::ACC_W-1:0] in_seed_sum;
  logic [rwc_pkg::ACC_W-1:0] in_seed_weighted;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic [rwc_pkg::ACC_W-1:0] out_sum_plain;
  logic [rwc_pkg::ACC_W-1:0] out_sum_weighted;
  logic [rwc_pkg::ACC_W-1:0] out_bytes_done;
  logic out_last_out;
  logic cfg_we;
  logic [rwc_pkg::OFFSET_W-1:0] cfg_wdata;

  // Shadow of the block's running state and its byte_offset register.
  logic [rwc_pkg::ACC_W-1:0] run_plain;
  logic [rwc_pkg::ACC_W-1:0] run_weighted;
  logic [rwc_pkg::ACC_W-1:0] run_count;
  logic [rwc_pkg::ACC_W-1:0] offset_shadow;

  beat_res_t pending_sums[$];
  int mismatch_count = 0;

  // Handshake between the stimulus process and the receiver process.
  logic quiet_link = 1'b0;   // no idling on either side while set
  logic squeeze_req = 1'b0;  // ask the receiver for one long hold-off

  rolling_weak_checksum_block dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_bytes    (in_data_bytes),
    .in_start_req     (in_start_req),
    .in_seed_sum      (in_seed_sum),
    .in_seed_weighted (in_seed_weighted),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sum_plain    (out_sum_plain),
    .out_sum_weighted (out_sum_weighted),
    .out_bytes_done   (out_bytes_done),
    .out_last_out     (out_last_out),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Advance the shadow state by one accepted request and return the result
  // the block should produce for it. Lanes above the carried bytes add zero.
  function automatic beat_res_t advance_checksum(input beat_req_t req);
    beat_res_t res;
    logic [rwc_pkg::ACC_W-1:0] lane;
    logic [rwc_pkg::ACC_W-1:0] lane_sum;
    logic [rwc_pkg::ACC_W-1:0] lane_wsum;
    logic [rwc_pkg::ACC_W-1:0] beat;
    logic [rwc_pkg::ACC_W-1:0] tri_weight;
    int k;
    beat = rwc_pkg::ACC_W'(rwc_pkg::BYTES_PER_BEAT);
    tri_weight = (beat * (beat + 1)) / 2;
    lane_sum = '0;
    lane_wsum = '0;
    // a start request reloads the sums and restarts the count first
    if (req.start) begin
      run_plain = req.seed_sum;
      run_weighted = req.seed_weighted;
      run_count = '0;
    end
    for (k = 0; k < rwc_pkg::BYTES_PER_BEAT; k++) begin
      lane = '0;
      if (k < rwc_pkg::DATA_BYTES) begin
        lane = {{(rwc_pkg::ACC_W-8){req.data[8*k+7]}}, req.data[8*k +: 8]};
      end
      lane_sum = lane_sum + lane;
      lane_wsum = lane_wsum + (beat - rwc_pkg::ACC_W'(k)) * lane;
    end
    // weighted sum picks up the old plain sum, so update it first
    run_weighted = run_weighted + beat * run_plain + lane_wsum + tri_weight * offset_shadow;
    run_plain = run_plain + lane_sum + beat * offset_shadow;
    run_count = run_count + beat;
    res.plain = run_plain;
    res.weighted = run_weighted;
    res.count = run_count;
    res.last = req.last;
    return res;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Byte lanes biased toward 0x00, 0x7F, 0x80 and 0xFF to hit sign edges.
  function automatic logic [rwc_pkg::DATA_W-1:0] random_bytes();
    logic [rwc_pkg::DATA_W-1:0] d;
    int k;
    d = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < rwc_pkg::DATA_BYTES; k++) begin
        case ($urandom_range(0, 7))
          0: d[8*k +: 8] = 8'h00;
          1: d[8*k +: 8] = 8'h7F;
          2: d[8*k +: 8] = 8'h80;
          3: d[8*k +: 8] = 8'hFF;
          default: d[8*k +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    return d;
  endfunction

  function automatic logic [rwc_pkg::ACC_W-1:0] random_seed();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted; record what it must yield.
  // Valid stays high on return unless a gap follows.
  task automatic offer_request(input beat_req_t req, input logic typed,
                               input beat_res_t typed_res);
    beat_res_t predicted;
    in_valid <= 1'b1;
    in_data_bytes <= req.data;
    in_start_req <= req.start;
    in_seed_sum <= req.seed_sum;
    in_seed_weighted <= req.seed_weighted;
    in_last <= req.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_checksum(req);
    pending_sums.push_back(typed ? typed_res : predicted);
    if (!quiet_link && $urandom_range(0, 99) >= 65) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Park the sender, wait until every outstanding result is back from the
  // two-stage pipe, and let it idle before returning.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input logic [rwc_pkg::OFFSET_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    offset_shadow = rwc_pkg::ACC_W'(value);
  endtask

  // Mostly well-formed runs (start, body, last) with random content; the
  // rest are single requests with every field random.
  task automatic random_phase(input int n_items, input logic squeeze);
    beat_req_t req;
    beat_res_t unused;
    int sent;
    int body;
    int k;
    sent = 0;
    unused = '0;
    if (squeeze) squeeze_req = 1'b1;
    while (sent < n_items) begin
      quiet_link = ($urandom_range(0, 99) < 15) || (squeeze && sent < 2 * SQUEEZE_CYCLES);
      if ($urandom_range(0, 99) < 85) begin
        body = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 40);
        for (k = 0; k <= body; k++) begin
          req.data = random_bytes();
          req.start = (k == 0);
          req.seed_sum = random_seed();
          req.seed_weighted = random_seed();
          req.last = (k == body);
          offer_request(req, 1'b0, unused);
          sent++;
        end
      end else begin
        req.data = random_bytes();
        req.start = 1'($urandom_range(0, 1));
        req.seed_sum = random_seed();
        req.seed_weighted = random_seed();
        req.last = 1'($urandom_range(0, 1));
        offer_request(req, 1'b0, unused);
        sent++;
      end
    end
    quiet_link = 1'b0;
  endtask

  task automatic compare_field(input string what, input logic [rwc_pkg::ACC_W-1:0] want,
                               input logic [rwc_pkg::ACC_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // Result side: pop the oldest expectation on every accepted result.
  always @(posedge clk) begin : result_check
    beat_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request outstanding, expected none actual %h %h %h %b",
                 $time, out_sum_plain, out_sum_weighted, out_bytes_done, out_last_out);
      end else begin
        want = pending_sums.pop_front();
        compare_field("sum_plain", want.plain, out_sum_plain);
        compare_field("sum_weighted", want.weighted, out_sum_weighted);
        compare_field("bytes_done", want.count, out_bytes_done);
        compare_field("last_out", rwc_pkg::ACC_W'(want.last), rwc_pkg::ACC_W'(out_last_out));
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while quiet.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (squeeze_req) begin
        // hold off long enough for the block to back up into its input
        squeeze_req = 1'b0;
        stall_left = SQUEEZE_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (quiet_link || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    beat_req_t req;
    beat_res_t typed_res;
    logic [rwc_pkg::OFFSET_W-1:0] phase_offset [5];
    int i;
    phase_offset[0] = 8'd255;
    phase_offset[1] = 8'd0;
    phase_offset[2] = 8'($urandom_range(2, 254));
    phase_offset[3] = 8'd1;
    phase_offset[4] = 8'($urandom_range(0, 255));

    // drive every input to a known value before the first edge
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_bytes <= '0;
    in_start_req <= 1'b0;
    in_seed_sum <= '0;
    in_seed_weighted <= '0;
    in_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    run_plain = '0;
    run_weighted = '0;
    run_count = '0;
    offset_shadow = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; byte_offset changes only with the pipe empty
    for (i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].set_offset) begin
        drain_results();
        write_offset(directed_rows[i].offset);
      end
      req.data = directed_rows[i].data;
      req.start = directed_rows[i].start;
      req.seed_sum = directed_rows[i].seed_sum;
      req.seed_weighted = directed_rows[i].seed_weighted;
      req.last = directed_rows[i].last;
      typed_res.plain = directed_rows[i].exp_plain;
      typed_res.weighted = directed_rows[i].exp_weighted;
      typed_res.count = directed_rows[i].exp_count;
      typed_res.last = directed_rows[i].last;
      offer_request(req, directed_rows[i].typed, typed_res);
    end

    // random phases, each under its own byte_offset; squeeze in the first
    for (i = 0; i < 5; i++) begin
      drain_results();
      write_offset(phase_offset[i]);
      random_phase(PHASE_ITEMS, i == 0);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_sums.size() == 0) begin
      $display("rolling_weak_checksum_block verification clean");
    end else begin
      $display("rolling_weak_checksum_block verification failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin : watchdog
    #5ms;
    $display("rolling_weak_checksum_block verification failed");
    $finish;
  end

endmodule

`default_nettype wire
